// ----- sv/pse_pkg.sv -----
// ----------------------------------------------------------------------------
// pse_pkg: shared types and codes of the postfix stack evaluator
// item kinds, operator codes, error codes and the alu request/response structs
// ----------------------------------------------------------------------------
`default_nettype none

package pse_pkg;

	localparam int unsigned DataW       = 32;
	localparam int unsigned StackDepthD = 64;
	localparam logic [DataW-1:0] Uint32Max = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		KIND_PUSH   = 2'd0,
		KIND_BINOP  = 2'd1,
		KIND_NOT    = 2'd2,
		KIND_FINISH = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		OP_ADD  = 4'd0,
		OP_SUB  = 4'd1,
		OP_MULT = 4'd2,
		OP_DIV  = 4'd3,
		OP_POW  = 4'd4,
		OP_REM  = 4'd5,
		OP_XOR  = 4'd6,
		OP_AND  = 4'd7,
		OP_OR   = 4'd8
	} opcode_t;

	typedef enum logic [1:0] {
		ERR_OK        = 2'd0,
		ERR_DIV_ZERO  = 2'd1,
		ERR_UNDERFLOW = 2'd2,
		ERR_OVERFLOW  = 2'd3
	} err_t;

	typedef struct packed {
		logic             start;
		logic [3:0]       op;
		logic [DataW-1:0] a;
		logic [DataW-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic             done;
		logic [DataW-1:0] result;
	} alu_rsp_t;

endpackage

`default_nettype wire

// ----- sv/pse_alu.sv -----
// ----------------------------------------------------------------------------
// pse_alu: shared multi-cycle arithmetic unit
// one 32x32 multiplier and one 33-bit subtractor, reused for mult, pow
// (square-and-multiply mod 2^32-1) and restoring division / remainder
// ----------------------------------------------------------------------------
`default_nettype none

module pse_alu
	import pse_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire alu_req_t req,
	output alu_rsp_t      rsp
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_DIV   = 7'b0000010,
		S_PMUL  = 7'b0000100,
		S_PRED  = 7'b0001000,
		S_PSQ   = 7'b0010000,
		S_SRED  = 7'b0100000,
		S_DONE  = 7'b1000000
	} alu_state_t;

	alu_state_t       state_q;
	logic [3:0]       op_q;
	logic [DataW-1:0] x_q;       // pow base or dividend shift register
	logic [DataW-1:0] e_q;       // pow exponent or divisor
	logic [DataW-1:0] r_q;       // pow accumulator or quotient
	logic [DataW:0]   rem_q;     // division partial remainder
	logic [5:0]       cnt_q;
	logic [2*DataW-1:0] prod_q;
	logic [DataW-1:0] res_q;

	// one shared multiplier
	logic [DataW-1:0]   mul_a;
	logic [DataW-1:0]   mul_b;
	logic [2*DataW-1:0] mul_p;
	assign mul_p = {{DataW{1'b0}}, mul_a} * {{DataW{1'b0}}, mul_b};

	always_comb begin
		mul_a = x_q;
		mul_b = x_q;
		if ((state_q == S_PMUL) && e_q[0]) begin
			mul_a = r_q;
		end
		if (state_q == S_IDLE) begin
			mul_a = req.a;
			mul_b = req.b;
		end
	end

	// reduction mod 2^32-1: hi + lo, fold carry, map all-ones to zero
	logic [DataW:0]   fold;
	logic [DataW-1:0] fold2;
	logic [DataW-1:0] red;
	assign fold  = {1'b0, prod_q[2*DataW-1:DataW]} + {1'b0, prod_q[DataW-1:0]};
	assign fold2 = fold[DataW-1:0] + {{(DataW-1){1'b0}}, fold[DataW]};
	assign red   = (fold2 == Uint32Max) ? '0 : fold2;

	// restoring division step
	logic [DataW:0] rem_sh;
	logic [DataW:0] rem_sub;
	assign rem_sh  = {rem_q[DataW-1:0], x_q[DataW-1]};
	assign rem_sub = rem_sh - {1'b0, e_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.start) begin
						op_q <= req.op;
						prod_q <= mul_p;
						case (req.op)
							OP_DIV, OP_REM: begin
								x_q     <= req.a;
								e_q     <= req.b;
								r_q     <= '0;
								rem_q   <= '0;
								cnt_q   <= 6'(DataW);
								state_q <= S_DIV;
							end
							OP_POW: begin
								// a 32-bit base is reduced mod 2^32-1 by mapping all-ones to zero
								x_q     <= (req.a == Uint32Max) ? '0 : req.a;
								e_q     <= req.b;
								r_q     <= 32'd1;
								state_q <= (req.b == '0) ? S_DONE : S_PMUL;
								res_q   <= 32'd1;
							end
							OP_MULT: begin
								res_q   <= mul_p[DataW-1:0];
								state_q <= S_DONE;
							end
							default: begin
								case (req.op)
									OP_ADD:  res_q <= req.a + req.b;
									OP_SUB:  res_q <= req.a - req.b;
									OP_XOR:  res_q <= req.a ^ req.b;
									OP_AND:  res_q <= req.a & req.b;
									default: res_q <= req.a | req.b;
								endcase
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_DIV: begin
					x_q <= {x_q[DataW-2:0], 1'b0};
					if (!rem_sub[DataW]) begin
						rem_q <= rem_sub;
						r_q   <= {r_q[DataW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						r_q   <= {r_q[DataW-2:0], 1'b0};
					end
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) begin
						state_q <= S_DONE;
						res_q   <= (op_q == OP_DIV) ? {r_q[DataW-2:0], ~rem_sub[DataW]}
							: (!rem_sub[DataW] ? rem_sub[DataW-1:0] : rem_sh[DataW-1:0]);
					end
				end
				S_PMUL: begin
					// multiply only when the exponent bit is set, else square right away
					prod_q <= mul_p;
					if (e_q[0]) begin
						state_q <= S_PRED;
					end else begin
						state_q <= S_SRED;
					end
				end
				S_PRED: begin
					r_q     <= red;
					prod_q  <= mul_p;
					state_q <= S_SRED;
				end
				S_SRED: begin
					x_q <= red;
					e_q <= e_q >> 1;
					if (e_q[DataW-1:1] == '0) begin
						res_q   <= r_q;
						state_q <= S_DONE;
					end else begin
						state_q <= S_PMUL;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.done   = (state_q == S_DONE);
	assign rsp.result = res_q;

endmodule

`default_nettype wire

// ----- sv/postfix_stack_evaluator.sv -----
// ----------------------------------------------------------------------------
// postfix_stack_evaluator: reverse-polish evaluator over 32-bit values
// operand stack in a memory, one shared multi-cycle alu, one result per request
// ----------------------------------------------------------------------------
// each request passes C_RD1, C_RD2 and C_EXEC; push, not, finish, faults and bad
// opcodes then go to C_OUT, alu ops via C_ALU and C_WB first; div and rem take one
// quotient bit a cycle; pow squares, and multiplies on set exponent bits, through
// the shared multiplier; one request at a time, the next can be taken in the cycle
// after its result is accepted; s_tready is low while a request is in work or its
// result waits; reset empties the stack, the stack memory itself is not cleared
`default_nettype none

module postfix_stack_evaluator
	import pse_pkg::*;
#(
	parameter int unsigned STACK_DEPTH = StackDepthD
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // kind[1:0], operand_value[33:2], opcode[37:34]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,  // top_value[31:0], error_code[33:32], stack_depth
	                                   // [40:34]
	output logic             m_tuser   // is_final
);

	localparam int unsigned AW = $clog2(STACK_DEPTH);
	localparam int unsigned PW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [6:0] {
		C_IDLE  = 7'b0000001,
		C_RD1   = 7'b0000010,
		C_RD2   = 7'b0000100,
		C_EXEC  = 7'b0001000,
		C_ALU   = 7'b0010000,
		C_WB    = 7'b0100000,
		C_OUT   = 7'b1000000
	} ctl_state_t;

	ctl_state_t       state_q;
	logic [1:0]       kind_q;
	logic [DataW-1:0] val_q;
	logic [3:0]       op_q;
	logic [PW-1:0]    sp_q;
	logic [DataW-1:0] a_q;
	logic [DataW-1:0] b_q;
	logic [DataW-1:0] top_q;
	logic [1:0]       err_q;
	logic             fin_q;

	// stack memory, one write and one registered read port
	logic [DataW-1:0] mem [STACK_DEPTH];
	logic             we;
	logic [AW-1:0]    waddr;
	logic [DataW-1:0] wdata;
	logic [AW-1:0]    raddr;
	logic [DataW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	alu_req_t alu_req;
	alu_rsp_t alu_rsp;

	pse_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	logic [PW-1:0] sp_m1;
	logic [PW-1:0] sp_m2;
	assign sp_m1 = sp_q - PW'(1);
	assign sp_m2 = sp_q - PW'(2);

	always_comb begin
		raddr = (state_q == C_IDLE) ? sp_m1[AW-1:0] : sp_m2[AW-1:0];
		we    = 1'b0;
		waddr = sp_m1[AW-1:0];
		wdata = alu_rsp.result;
		if (state_q == C_EXEC) begin
			case (kind_q)
				KIND_PUSH: begin
					we    = (sp_q < PW'(STACK_DEPTH));
					waddr = sp_q[AW-1:0];
					wdata = val_q;
				end
				KIND_NOT: begin
					we    = (sp_q != '0);
					wdata = ~a_q;
				end
				default: we = 1'b0;
			endcase
		end
		if (state_q == C_WB) begin
			we    = (err_q == ERR_OK);
			waddr = sp_m2[AW-1:0];
		end
		alu_req.start = (state_q == C_EXEC) && (kind_q == KIND_BINOP)
			&& (op_q <= OP_OR) && (sp_q >= PW'(2))
			&& !(((op_q == OP_DIV) || (op_q == OP_REM)) && (a_q == '0));
		alu_req.op = op_q;
		alu_req.a  = b_q;
		alu_req.b  = a_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			sp_q    <= '0;
		end else begin
			case (state_q)
				C_IDLE: begin
					if (s_tvalid) begin
						kind_q  <= s_tdata[1:0];
						val_q   <= s_tdata[33:2];
						op_q    <= s_tdata[37:34];
						state_q <= C_RD1;
					end
				end
				C_RD1: begin
					a_q     <= rdata_q;      // top entry
					state_q <= C_RD2;
				end
				C_RD2: begin
					b_q     <= rdata_q;      // entry below top
					state_q <= C_EXEC;
				end
				C_EXEC: begin
					err_q <= ERR_OK;
					fin_q <= 1'b0;
					top_q <= (sp_q == '0) ? '0 : a_q;
					state_q <= C_OUT;
					case (kind_q)
						KIND_PUSH: begin
							if (sp_q < PW'(STACK_DEPTH)) begin
								sp_q  <= sp_q + PW'(1);
								top_q <= val_q;
							end else begin
								err_q <= ERR_OVERFLOW;
							end
						end
						KIND_BINOP: begin
							if (op_q <= OP_OR) begin
								if (sp_q < PW'(2)) begin
									err_q <= ERR_UNDERFLOW;
								end else if (((op_q == OP_DIV) || (op_q == OP_REM))
									&& (a_q == '0)) begin
									err_q <= ERR_DIV_ZERO;
								end else begin
									state_q <= C_ALU;
								end
							end
						end
						KIND_NOT: begin
							if (sp_q == '0) begin
								err_q <= ERR_UNDERFLOW;
							end else begin
								top_q <= ~a_q;
							end
						end
						default: begin
							fin_q <= 1'b1;
							sp_q  <= '0;
							if (sp_q == '0) begin
								err_q <= ERR_UNDERFLOW;
							end
						end
					endcase
				end
				C_ALU: begin
					if (alu_rsp.done) begin
						state_q <= C_WB;
					end
				end
				C_WB: begin
					sp_q    <= sp_m1;
					top_q   <= alu_rsp.result;
					state_q <= C_OUT;
				end
				C_OUT: begin
					if (m_tready) begin
						state_q <= C_IDLE;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == C_IDLE);
	assign m_tvalid = (state_q == C_OUT);
	assign m_tdata  = {7'd0, 7'(sp_q), err_q, top_q};
	assign m_tuser  = fin_q;

	// write-back comes only after the alu has signalled done; the alu result register holds the value
	a_wb_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == C_WB) |-> $past(alu_rsp.done))
		else $error("write-back without alu completion");
	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= PW'(STACK_DEPTH))
		else $error("stack pointer beyond depth");
	a_final_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (sp_q == '0))
		else $error("finish left entries on the stack");

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench of the postfix stack evaluator
// directed table of pushes, operators, not and finish, a fill to overflow, then random expressions;
// every result is checked against a behavioral stack predictor in order
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import pse_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NRand = 1850;

	typedef struct packed {
		logic [31:0] top;
		err_t        err;
		logic [6:0]  depth;
		logic        fin;
	} rsp_t;

	typedef struct {
		kind_t       kind;
		logic [31:0] val;
		logic [3:0]  op;
		logic        chk;
		rsp_t        rsp;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tuser;

	postfix_stack_evaluator dut (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser
	);

	always #5 clk = ~clk;

	// predictor state
	logic [31:0] stk [StackDepthD];
	int unsigned sp = 0;
	rsp_t        pending_results [$];
	rsp_t        typed_results [$];   // fixed answers of directed rows
	logic        typed_valid [$];
	int          errors = 0;
	int          n_sent = 0, n_recv = 0, n_final = 0, n_fault = 0;
	int          send_idle = 0, recv_stall = 0;
	int          hold_cycles = 0;

	task automatic report(input string what, input logic [47:0] got, input logic [47:0] want);
		errors++;
		$display("mismatch %s: got %h want %h (result %0d)", what, got, want, n_recv);
	endtask

	function automatic logic [31:0] pow_mod(input logic [31:0] b, input logic [31:0] e);
		logic [63:0] r, x;
		r = 64'd1;
		x = {32'd0, b};
		for (int i = 0; i < 32; i++) begin
			if (e[i]) r = (r * x) % 64'hFFFF_FFFF;
			x = (x * x) % 64'hFFFF_FFFF;
		end
		return r[31:0];
	endfunction

	function automatic rsp_t evaluate(input kind_t kind, input logic [31:0] val,
	                                  input logic [3:0] op);
		rsp_t        r;
		logic [31:0] a, b, q;
		logic        ok;
		r = '0;
		r.err = ERR_OK;
		case (kind)
			KIND_PUSH: begin
				if (sp >= StackDepthD) r.err = ERR_OVERFLOW;
				else begin
					stk[sp] = val;
					sp++;
				end
			end
			KIND_BINOP: begin
				if (op <= OP_OR) begin
					if (sp < 2) r.err = ERR_UNDERFLOW;
					else begin
						a = stk[sp-2];
						b = stk[sp-1];
						ok = 1'b1;
						q = '0;
						case (opcode_t'(op))
							OP_ADD:  q = a + b;
							OP_SUB:  q = a - b;
							OP_MULT: q = a * b;
							OP_DIV:  if (b == 0) ok = 1'b0; else q = a / b;
							OP_POW:  q = pow_mod(a, b);
							OP_REM:  if (b == 0) ok = 1'b0; else q = a % b;
							OP_XOR:  q = a ^ b;
							OP_AND:  q = a & b;
							default: q = a | b;
						endcase
						if (ok) begin
							sp--;
							stk[sp-1] = q;
						end else r.err = ERR_DIV_ZERO;
					end
				end
			end
			KIND_NOT: begin
				if (sp == 0) r.err = ERR_UNDERFLOW;
				else stk[sp-1] = ~stk[sp-1];
			end
			default: begin
				r.fin = 1'b1;
				if (sp == 0) r.err = ERR_UNDERFLOW;
				else r.top = stk[sp-1];
				sp = 0;
			end
		endcase
		if (kind != KIND_FINISH) r.top = (sp == 0) ? 32'd0 : stk[sp-1];
		r.depth = sp[6:0];
		return r;
	endfunction

	// drives at the falling edge, returns at the rising edge that takes the request
	task automatic send(input kind_t kind, input logic [31:0] val, input logic [3:0] op);
		rsp_t r;
		@(negedge clk);
		if (send_idle > 0 && $urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
			while (send_idle > 0 && $urandom_range(99) < send_idle) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, op, val, kind};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		r = evaluate(kind, val, op);
		pending_results.push_back(r);
		if (r.err != ERR_OK) n_fault++;
		n_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_val();
		case ($urandom_range(5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(15);
			3: return 32'd1 << $urandom_range(31);
			default: return $urandom;
		endcase
	endfunction

	// one well-formed expression with random content, sometimes broken
	task automatic random_expr();
		int n;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++) send(KIND_PUSH, rand_val(), 4'($urandom_range(15)));
		for (int i = 0; i < n - 1; i++) begin
			if ($urandom_range(5) == 0) send(KIND_NOT, $urandom, 4'($urandom_range(15)));
			else if ($urandom_range(11) == 0)
				send(KIND_BINOP, $urandom, 4'($urandom_range(9, 15)));
			else send(KIND_BINOP, $urandom, 4'($urandom_range(0, 8)));
		end
		if ($urandom_range(7) == 0)
			send(kind_t'($urandom_range(3)), $urandom, 4'($urandom_range(15)));
		send(KIND_FINISH, $urandom, 4'($urandom_range(15)));
	endtask

	// receiver and checker
	always @(posedge clk) begin
		rsp_t got, want;
		got = {m_tdata[31:0], m_tdata[33:32], m_tdata[40:34], m_tuser};
		if (m_tvalid && m_tready) begin
			n_recv++;
			if (got.fin) n_final++;
			if (pending_results.size() == 0) report("unexpected result", got, '0);
			else begin
				want = pending_results.pop_front();
				if (got.top !== want.top) report("top_value", got.top, want.top);
				if (got.err !== want.err) report("error_code", got.err, want.err);
				if (got.depth !== want.depth) report("stack_depth", got.depth, want.depth);
				if (got.fin !== want.fin) report("is_final", got.fin, want.fin);
				if (typed_valid.size() != 0) begin
					if (typed_valid.pop_front() && got !== typed_results[0])
						report("directed row", got, typed_results[0]);
					void'(typed_results.pop_front());
				end
			end
		end
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else m_tready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
	end

	initial begin
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		row_t table_rows [$];
		row_t w;
		int   phase;
		// directed rows: fixed answers where obvious
		table_rows = '{
			'{KIND_FINISH, 32'd0, 4'd0, 1'b1, '{32'd0, ERR_UNDERFLOW, 7'd0, 1'b1}},
			'{KIND_NOT, 32'd0, 4'd0, 1'b1, '{32'd0, ERR_UNDERFLOW, 7'd0, 1'b0}},
			'{KIND_BINOP, 32'd0, OP_ADD, 1'b1, '{32'd0, ERR_UNDERFLOW, 7'd0, 1'b0}},
			'{KIND_PUSH, 32'hFFFF_FFFF, 4'd0, 1'b1, '{32'hFFFF_FFFF, ERR_OK, 7'd1, 1'b0}},
			'{KIND_BINOP, 32'd0, OP_SUB, 1'b1, '{32'hFFFF_FFFF, ERR_UNDERFLOW, 7'd1, 1'b0}},
			'{KIND_PUSH, 32'd0, 4'd0, 1'b1, '{32'd0, ERR_OK, 7'd2, 1'b0}},
			'{KIND_BINOP, 32'd0, OP_DIV, 1'b1, '{32'd0, ERR_DIV_ZERO, 7'd2, 1'b0}},
			'{KIND_BINOP, 32'd0, OP_REM, 1'b1, '{32'd0, ERR_DIV_ZERO, 7'd2, 1'b0}},
			'{KIND_BINOP, 32'd0, 4'd15, 1'b1, '{32'd0, ERR_OK, 7'd2, 1'b0}},
			'{KIND_BINOP, 32'd0, OP_POW, 1'b1, '{32'd1, ERR_OK, 7'd1, 1'b0}},
			'{KIND_PUSH, 32'h8000_0001, 4'd0, 1'b0, '0},
			'{KIND_BINOP, 32'd0, OP_ADD, 1'b0, '0},
			'{KIND_PUSH, 32'd7, 4'd0, 1'b0, '0},
			'{KIND_BINOP, 32'd0, OP_MULT, 1'b0, '0},
			'{KIND_PUSH, 32'hFFFF_FFFE, 4'd0, 1'b0, '0},
			'{KIND_BINOP, 32'd0, OP_POW, 1'b0, '0},
			'{KIND_PUSH, 32'd3, 4'd0, 1'b0, '0},
			'{KIND_BINOP, 32'd0, OP_DIV, 1'b0, '0},
			'{KIND_PUSH, 32'd5, 4'd0, 1'b0, '0},
			'{KIND_BINOP, 32'd0, OP_REM, 1'b0, '0},
			'{KIND_PUSH, 32'hA5A5_5A5A, 4'd0, 1'b0, '0},
			'{KIND_BINOP, 32'd0, OP_XOR, 1'b0, '0},
			'{KIND_NOT, 32'hFFFF_FFFF, 4'd0, 1'b0, '0},
			'{KIND_PUSH, 32'h0F0F_F0F0, 4'd0, 1'b0, '0},
			'{KIND_BINOP, 32'd0, OP_AND, 1'b0, '0},
			'{KIND_PUSH, 32'h1234_5678, 4'd0, 1'b0, '0},
			'{KIND_BINOP, 32'd0, OP_OR, 1'b0, '0},
			'{KIND_FINISH, 32'd0, 4'd0, 1'b1, '{32'd0, ERR_UNDERFLOW, 7'd0, 1'b1}}
		};
		// last row is a finish after ops leave one entry: not fixed after all
		table_rows[table_rows.size()-1].chk = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (table_rows[i]) begin
			w = table_rows[i];
			typed_valid.push_back(w.chk);
			typed_results.push_back(w.rsp);
			send(w.kind, w.val, w.op);
		end
		drain();
		// fill to the top and overflow, with a long receiver hold during the fill so the input stalls
		for (int i = 0; i < StackDepthD + 2; i++) begin
			if (i == 10) hold_cycles = 400;
			send(KIND_PUSH, $urandom, 4'($urandom_range(15)));
		end
		for (int i = 0; i < StackDepthD; i++)
			send(KIND_BINOP, $urandom, 4'($urandom_range(0, 8)));
		send(KIND_FINISH, $urandom, 4'($urandom_range(15)));
		drain();
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 78; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 78; end
				default: begin send_idle = 35; recv_stall = 35; end
			endcase
			while (n_sent < (phase + 1) * NRand / 4) random_expr();
			drain();
		end
		repeat (120) @(negedge clk);
		$display("sent %0d requests, %0d results (%0d finals, %0d faults)",
		         n_sent, n_recv, n_final, n_fault);
		$display("covered all operators, not, finish, overflow, underflow, zero divisors");
		if (errors == 0 && pending_results.size() == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
